// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use samples on the rising edge of clk
// and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed one cycle later");

`endif

// File: rtl/pmma_pkg.sv
`default_nettype none
package pmma_pkg;

  // Fixed widths of the accumulated state and of the results.
  localparam int MASS_W    = 32;
  localparam int MOM_W     = 48;
  localparam int CENTRE_W  = 24;
  localparam int DIAG_W    = 63;
  localparam int CROSS_W   = 64;

  // Centroid division: Q.8 result, rounded, so the numerator is mag*512 + mass.
  localparam int FRAC_SHIFT = 9;
  localparam int NUM_W      = MOM_W + FRAC_SHIFT + 1;
  localparam int DIV_STEPS  = CENTRE_W;

  // Saturation bound shared by the second-moment sums.
  localparam logic [DIAG_W-1:0] CAP63 = {DIAG_W{1'b1}};

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WEIGHT  = 2'd1;

  // Control from the sequencer to each centroid divider.
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/pmma_div.sv
`default_nettype none
// Restoring divider for one centroid axis: one quotient bit per cycle while ctrl.step
// is high, with a single up-front check for a quotient that cannot fit.
module pmma_div (
  input  wire logic                                   clk,
  input  wire pmma_pkg::div_ctrl_t                    ctrl,
  input  wire logic [pmma_pkg::MOM_W-1:0]             mag,
  input  wire logic                                   neg,
  input  wire logic [pmma_pkg::MASS_W-1:0]            mass,
  output logic signed [pmma_pkg::CENTRE_W-1:0]        centre
);

  localparam int NW = pmma_pkg::NUM_W;
  localparam int QW = pmma_pkg::CENTRE_W;

  logic [NW-1:0] rem_r, dsh_r;
  logic [NW-1:0] num_ld, div2;
  logic [QW-1:0] q_r, qmag;
  logic          ovf_r, neg_r, zero_r;

  // Numerator and doubled divisor for a new division.
  assign num_ld = NW'({mag, {pmma_pkg::FRAC_SHIFT{1'b0}}}) + NW'(mass);
  assign div2   = NW'({mass, 1'b0});

  // Load, then subtract the shifted divisor where it fits, once per step.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r  <= num_ld;
      dsh_r  <= div2 << (QW - 1);
      ovf_r  <= num_ld >= (div2 << QW);
      q_r    <= '0;
      neg_r  <= neg;
      zero_r <= (mass == '0);
    end else if (ctrl.step) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  // Clamp to the signed 24-bit range and apply the sign; a zero mass gives a zero centre.
  always_comb begin
    qmag = q_r;
    if (neg_r) begin
      if (ovf_r || (q_r > {1'b1, {(QW-1){1'b0}}})) begin
        qmag = {1'b1, {(QW-1){1'b0}}};
      end
      centre = -$signed(qmag);
    end else begin
      if (ovf_r || q_r[QW-1]) begin
        qmag = {1'b0, {(QW-1){1'b1}}};
      end
      centre = $signed(qmag);
    end
    if (zero_r) begin
      centre = '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/point_mass_moment_accumulator.sv
`default_nettype none
// Channel  Direction  Handshake              Beat contents
// in       input      in_valid / in_ready    restart, x/y/z coordinates, weight
// out      output     out_valid / out_ready  mass, centroid, six inertia sums, bad_weight
// cfg      input      cfg_we                 cfg_index, cfg_wdata (write only)
//
// In a good beat the squares are built one coordinate bit per cycle, the products with the
// weight one weight bit per cycle, and the three centroid dividers give one quotient bit
// per cycle. A rejected beat skips the multiplies and the accumulation and goes straight
// to the dividers. One beat is in work at a time; a finished result waits in the output
// register while the next beat is accepted. Reset is synchronous and clears all sums.
module point_mass_moment_accumulator #(
  parameter int COORD_BITS  = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_restart,
  input  wire logic signed [COORD_BITS-1:0]         in_x_coord,
  input  wire logic signed [COORD_BITS-1:0]         in_y_coord,
  input  wire logic signed [COORD_BITS-1:0]         in_z_coord,
  input  wire logic [WEIGHT_BITS-1:0]               in_weight,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [pmma_pkg::MASS_W-1:0]               out_total_mass,
  output logic signed [pmma_pkg::CENTRE_W-1:0]      out_centre_x,
  output logic signed [pmma_pkg::CENTRE_W-1:0]      out_centre_y,
  output logic signed [pmma_pkg::CENTRE_W-1:0]      out_centre_z,
  output logic [pmma_pkg::DIAG_W-1:0]               out_inertia_xx,
  output logic [pmma_pkg::DIAG_W-1:0]               out_inertia_yy,
  output logic [pmma_pkg::DIAG_W-1:0]               out_inertia_zz,
  output logic signed [pmma_pkg::CROSS_W-1:0]       out_inertia_xy,
  output logic signed [pmma_pkg::CROSS_W-1:0]       out_inertia_xz,
  output logic signed [pmma_pkg::CROSS_W-1:0]       out_inertia_yz,
  output logic                                      out_bad_weight,
  input  wire logic                                 cfg_we,
  input  wire logic [pmma_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pmma_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int C    = COORD_BITS;
  localparam int W    = WEIGHT_BITS;
  localparam int SQW  = 2 * C;
  localparam int MW   = C + W;
  localparam int PW   = 2 * C + W;
  localparam int EW   = (PW > 64) ? PW : 64;
  localparam int CW   = (W > pmma_pkg::CFG_DATA_W) ? W : pmma_pkg::CFG_DATA_W;
  localparam int MAXA = (C > W) ? C : W;
  localparam int MAXN = (MAXA > pmma_pkg::DIV_STEPS) ? MAXA : pmma_pkg::DIV_STEPS;
  localparam int CNT_W = $clog2(MAXN + 1);
  localparam int MOMW = pmma_pkg::MOM_W;
  localparam int DGW  = pmma_pkg::DIAG_W;
  localparam int CRW  = pmma_pkg::CROSS_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_WMUL = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_DSET = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  localparam logic signed [MOMW+1:0] MOM_MAX = (MOMW+2)'({1'b0, {(MOMW-1){1'b1}}});
  localparam logic signed [MOMW+1:0] MOM_MIN = -(MOMW+2)'({1'b1, {(MOMW-1){1'b0}}});
  localparam logic signed [CRW:0]    CAP65   = (CRW+1)'(pmma_pkg::CAP63);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             use_w_r;
  logic [pmma_pkg::CFG_DATA_W-1:0] min_w_r;
  logic             restart_r, bad_r;
  logic [2:0]       sgn_r;
  logic [C-1:0]     mag_r  [3];
  logic [C-1:0]     bits_r [3];
  logic [SQW-1:0]   sq_r   [6];
  logic [SQW-1:0]   dg_r   [3];
  logic [W-1:0]     w_r, ws_r;
  logic [MW-1:0]    am_r   [3];
  logic [PW-1:0]    ad_r   [3];
  logic [PW-1:0]    ac_r   [3];

  logic [pmma_pkg::MASS_W-1:0] mass_r, mass_nxt;
  logic signed [MOMW-1:0]      mom_r   [3];
  logic signed [MOMW-1:0]      mom_nxt [3];
  logic [DGW-1:0]              dsum_r  [3];
  logic [DGW-1:0]              dsum_nxt[3];
  logic signed [CRW-1:0]       csum_r  [3];
  logic signed [CRW-1:0]       csum_nxt[3];

  logic                        out_valid_r, out_bad_r;
  logic [pmma_pkg::MASS_W-1:0] out_mass_r;
  logic signed [pmma_pkg::CENTRE_W-1:0] out_cen_r [3];
  logic [DGW-1:0]              out_dg_r [3];
  logic signed [CRW-1:0]       out_cr_r [3];

  logic [W-1:0]     w_eff;
  logic             bad_in, capture, done_load;
  logic [C-1:0]     in_mag [3];
  logic [2:0]       in_sgn;
  logic [MOMW-1:0]  div_mag [3];
  logic signed [pmma_pkg::CENTRE_W-1:0] centre [3];
  pmma_pkg::div_ctrl_t dctl;

  // Working variables of the accumulate step.
  logic [pmma_pkg::MASS_W:0]   msum;
  logic signed [MOMW+1:0]      mterm, mtot;
  logic [EW-1:0]               dext, cext;
  logic [DGW-1:0]              dprod, cmag;
  logic [DGW:0]                dtot;
  logic signed [CRW:0]         cterm, ctot;

  assign in_ready  = (state_r == ST_IDLE);
  assign capture   = in_valid && in_ready;
  assign done_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Effective weight and the rejection test on the incoming beat.
  assign w_eff  = use_w_r ? in_weight : W'(1);
  assign bad_in = CW'(w_eff) <= CW'(min_w_r);
  assign in_sgn = {in_z_coord[C-1], in_y_coord[C-1], in_x_coord[C-1]};
  assign in_mag[0] = in_x_coord[C-1] ? C'(-in_x_coord) : in_x_coord;
  assign in_mag[1] = in_y_coord[C-1] ? C'(-in_y_coord) : in_y_coord;
  assign in_mag[2] = in_z_coord[C-1] ? C'(-in_z_coord) : in_z_coord;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (capture) begin
          state_nxt = bad_in ? ST_DSET : ST_SQR;
          cnt_nxt   = CNT_W'(C - 1);
        end
      end
      ST_SQR: begin
        if (cnt_r == '0) begin
          state_nxt = ST_SUM;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SUM: begin
        state_nxt = ST_WMUL;
        cnt_nxt   = CNT_W'(W - 1);
      end
      ST_WMUL: begin
        if (cnt_r == '0) begin
          state_nxt = ST_ACC;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_ACC: begin
        state_nxt = ST_DSET;
      end
      ST_DSET: begin
        state_nxt = ST_DIV;
        cnt_nxt   = CNT_W'(pmma_pkg::DIV_STEPS - 1);
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (done_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Saturating update of every sum, with restart clearing the old values first.
  always_comb begin
    msum     = {1'b0, (restart_r ? '0 : mass_r)} + (pmma_pkg::MASS_W+1)'(w_r);
    mass_nxt = msum[pmma_pkg::MASS_W] ? '1 : msum[pmma_pkg::MASS_W-1:0];
    mterm = '0; mtot = '0; dext = '0; dprod = '0; dtot = '0;
    cext = '0; cmag = '0; cterm = '0; ctot = '0;
    for (int k = 0; k < 3; k++) begin
      // First moments.
      mterm = (MOMW+2)'(am_r[k]);
      if (sgn_r[k]) begin
        mterm = -mterm;
      end
      mtot = (restart_r ? '0 : (MOMW+2)'(mom_r[k])) + mterm;
      if (mtot > MOM_MAX) begin
        mom_nxt[k] = MOMW'(MOM_MAX);
      end else if (mtot < MOM_MIN) begin
        mom_nxt[k] = MOMW'(MOM_MIN);
      end else begin
        mom_nxt[k] = mtot[MOMW-1:0];
      end
      // Diagonal sums.
      dext  = EW'(ad_r[k]);
      dprod = (dext > EW'(pmma_pkg::CAP63)) ? pmma_pkg::CAP63 : dext[DGW-1:0];
      dtot  = {1'b0, (restart_r ? '0 : dsum_r[k])} + {1'b0, dprod};
      dsum_nxt[k] = dtot[DGW] ? pmma_pkg::CAP63 : dtot[DGW-1:0];
      // Product sums: the term is negative when both coordinates share a sign.
      cext  = EW'(ac_r[k]);
      cmag  = (cext > EW'(pmma_pkg::CAP63)) ? pmma_pkg::CAP63 : cext[DGW-1:0];
      cterm = (CRW+1)'(cmag);
      if (((k == 2) ? sgn_r[1] : sgn_r[0]) == ((k == 0) ? sgn_r[1] : sgn_r[2])) begin
        cterm = -cterm;
      end
      ctot = (restart_r ? '0 : (CRW+1)'(csum_r[k])) + cterm;
      if (ctot > CAP65) begin
        csum_nxt[k] = CRW'(CAP65);
      end else if (ctot < -CAP65) begin
        csum_nxt[k] = CRW'(-CAP65);
      end else begin
        csum_nxt[k] = ctot[CRW-1:0];
      end
    end
  end

  // Control state, configuration and accumulated sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      use_w_r     <= 1'b1;
      min_w_r     <= '0;
      out_valid_r <= 1'b0;
      mass_r      <= '0;
      for (int k = 0; k < 3; k++) begin
        mom_r[k]  <= '0;
        dsum_r[k] <= '0;
        csum_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pmma_pkg::REG_USE_WEIGHTS: use_w_r <= cfg_wdata[0];
          pmma_pkg::REG_MIN_WEIGHT:  min_w_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_ACC) begin
        mass_r <= mass_nxt;
        for (int k = 0; k < 3; k++) begin
          mom_r[k]  <= mom_nxt[k];
          dsum_r[k] <= dsum_nxt[k];
          csum_r[k] <= csum_nxt[k];
        end
      end
      if (done_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Serial multipliers: squares and cross products by coordinate bits, then
  // everything by the weight bits, most significant bit first.
  always_ff @(posedge clk) begin
    if (capture) begin
      restart_r <= in_restart;
      bad_r     <= bad_in;
      sgn_r     <= in_sgn;
      w_r       <= w_eff;
      ws_r      <= w_eff;
      for (int k = 0; k < 3; k++) begin
        mag_r[k]  <= in_mag[k];
        bits_r[k] <= in_mag[k];
        am_r[k]   <= '0;
        ad_r[k]   <= '0;
        ac_r[k]   <= '0;
      end
      for (int k = 0; k < 6; k++) begin
        sq_r[k] <= '0;
      end
    end
    if (state_r == ST_SQR) begin
      for (int k = 0; k < 3; k++) begin
        bits_r[k] <= {bits_r[k][C-2:0], 1'b0};
        sq_r[k]   <= {sq_r[k][SQW-2:0], 1'b0} +
                     (bits_r[k][C-1] ? SQW'(mag_r[k]) : '0);
      end
      sq_r[3] <= {sq_r[3][SQW-2:0], 1'b0} + (bits_r[1][C-1] ? SQW'(mag_r[0]) : '0);
      sq_r[4] <= {sq_r[4][SQW-2:0], 1'b0} + (bits_r[2][C-1] ? SQW'(mag_r[0]) : '0);
      sq_r[5] <= {sq_r[5][SQW-2:0], 1'b0} + (bits_r[2][C-1] ? SQW'(mag_r[1]) : '0);
    end
    if (state_r == ST_SUM) begin
      dg_r[0] <= sq_r[1] + sq_r[2];
      dg_r[1] <= sq_r[0] + sq_r[2];
      dg_r[2] <= sq_r[0] + sq_r[1];
    end
    if (state_r == ST_WMUL) begin
      ws_r <= ws_r << 1;
      for (int k = 0; k < 3; k++) begin
        am_r[k] <= {am_r[k][MW-2:0], 1'b0} + (ws_r[W-1] ? MW'(mag_r[k]) : '0);
        ad_r[k] <= {ad_r[k][PW-2:0], 1'b0} + (ws_r[W-1] ? PW'(dg_r[k]) : '0);
        ac_r[k] <= {ac_r[k][PW-2:0], 1'b0} + (ws_r[W-1] ? PW'(sq_r[3+k]) : '0);
      end
    end
  end

  // Centroid dividers, one per axis, fed with the moment magnitudes.
  assign dctl.load = (state_r == ST_DSET);
  assign dctl.step = (state_r == ST_DIV);

  for (genvar g = 0; g < 3; g++) begin : g_div
    assign div_mag[g] = mom_r[g][MOMW-1] ? MOMW'(-mom_r[g]) : mom_r[g];
    pmma_div u_div (
      .clk    (clk),
      .ctrl   (dctl),
      .mag    (div_mag[g]),
      .neg    (mom_r[g][MOMW-1]),
      .mass   (mass_r),
      .centre (centre[g])
    );
  end

  // Output register: holds the finished result while the next beat is in work.
  always_ff @(posedge clk) begin
    if (done_load) begin
      out_mass_r <= mass_r;
      out_bad_r  <= bad_r;
      for (int k = 0; k < 3; k++) begin
        out_cen_r[k] <= centre[k];
        out_dg_r[k]  <= dsum_r[k];
        out_cr_r[k]  <= csum_r[k];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_total_mass = out_mass_r;
  assign out_centre_x   = out_cen_r[0];
  assign out_centre_y   = out_cen_r[1];
  assign out_centre_z   = out_cen_r[2];
  assign out_inertia_xx = out_dg_r[0];
  assign out_inertia_yy = out_dg_r[1];
  assign out_inertia_zz = out_dg_r[2];
  assign out_inertia_xy = out_cr_r[0];
  assign out_inertia_xz = out_cr_r[1];
  assign out_inertia_yz = out_cr_r[2];
  assign out_bad_weight = out_bad_r;

  // Checks on the sequencer and the sums.
`include "assert_macros.svh"
  `ASSERT_NEXT(a_busy_after_accept, capture, state_r != ST_IDLE)
  `ASSERT_SAME(a_no_acc_on_reject, state_r == ST_ACC, !bad_r)
  `ASSERT_SAME(a_good_has_mass, out_valid && !out_bad_weight, out_total_mass != '0)

endmodule
`default_nettype wire
